/* hdl/sset_pkg.sv */
`default_nettype none

package sset_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int KEY_W     = 32;
    localparam int POS_W     = 7;
    localparam int CNT_W     = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic             found;
        logic             rejected_full;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] stored_count;
    } t_result;

endpackage

`default_nettype wire

/* hdl/sorted_set_insert.sv */
// channel  | valid    | stall    | payload
// ---------+----------+----------+---------------------------------------------------
// input    | i_valid  | o_stall  | i_new_key
// output   | o_valid  | i_stall  | o_found, o_rejected_full, o_position, o_stored_count
//
// one key per transaction, one result per key
// a key takes one ram read per entry during the ordered scan, then one read
// and one write per cycle while larger entries move up; the single-port-pair
// key ram sets that rate; a result waits in an output register
// reset clears the entry count and control state; ram contents need no clearing
// a stalled result holds the sequencer only when the next one is ready to leave

`default_nettype none

module sorted_set_insert
    import sset_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output      logic             o_stall,
    input  wire logic [KEY_W-1:0] i_new_key,
    output      logic             o_valid,
    input  wire logic             i_stall,
    output      logic             o_found,
    output      logic             o_rejected_full,
    output      logic [POS_W-1:0] o_position,
    output      logic [CNT_W-1:0] o_stored_count
);

    localparam int AW = $clog2(DEPTH);

    logic             r_out_vld;
    t_result          r_res;
    t_result          res;
    logic             res_vld;
    logic             res_hold;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [KEY_W-1:0] wdata;
    logic [AW-1:0]    raddr;
    logic [KEY_W-1:0] rdata;

    assign res_hold = r_out_vld && i_stall;

    sset_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_key      (i_new_key),
        .o_busy     (o_stall),
        .i_res_hold (res_hold),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    sset_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
        if (res_vld) begin
            r_res <= res;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_found         = r_res.found;
    assign o_rejected_full = r_res.rejected_full;
    assign o_position      = r_res.position;
    assign o_stored_count  = r_res.stored_count;

endmodule

`default_nettype wire

/* hdl/sset_ram.sv */
`default_nettype none

module sset_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/sset_ctrl.sv */
`default_nettype none

module sset_ctrl
    import sset_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [KEY_W-1:0]         i_key,
    output      logic                     o_busy,
    input  wire logic                     i_res_hold,
    output      logic                     o_res_vld,
    output      t_result                  o_res,
    output      logic                     o_we,
    output      logic [$clog2(DEPTH)-1:0] o_waddr,
    output      logic [KEY_W-1:0]         o_wdata,
    output      logic [$clog2(DEPTH)-1:0] o_raddr,
    input  wire logic [KEY_W-1:0]         i_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH + 1);

    t_state           r_state, n_state;
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_carry, n_carry;
    logic [IW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_pos, n_pos;
    logic             r_found, n_found;
    logic             r_rej, n_rej;

    logic [IW-1:0]    idx_inc;
    logic             at_end;
    logic             full;

    assign idx_inc = r_idx + 1'b1;
    assign at_end  = (r_idx == r_cnt);
    assign full    = (r_cnt == IW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_key   <= n_key;
        r_carry <= n_carry;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_found <= n_found;
        r_rej   <= n_rej;
    end

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_carry   = r_carry;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_found   = r_found;
        n_rej     = r_rej;
        o_we      = 1'b0;
        o_waddr   = r_idx[AW-1:0];
        o_wdata   = r_key;
        o_raddr   = idx_inc[AW-1:0];
        o_res_vld = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_raddr = '0;
                if (i_valid) begin
                    n_key   = i_key;
                    n_idx   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (at_end) begin
                    n_found = 1'b0;
                    n_state = ST_FINISH;
                    if (full) begin
                        n_rej = 1'b1;
                        n_pos = '0;
                    end else begin
                        n_rej = 1'b0;
                        o_we  = 1'b1;
                        n_pos = r_idx[AW-1:0];
                        n_cnt = r_cnt + 1'b1;
                    end
                end else if (i_rdata == r_key) begin
                    n_found = 1'b1;
                    n_rej   = 1'b0;
                    n_pos   = r_idx[AW-1:0];
                    n_state = ST_FINISH;
                end else if ($signed(i_rdata) < $signed(r_key)) begin
                    n_idx = idx_inc;
                end else begin
                    n_found = 1'b0;
                    if (full) begin
                        n_rej   = 1'b1;
                        n_pos   = '0;
                        n_state = ST_FINISH;
                    end else begin
                        n_rej   = 1'b0;
                        o_we    = 1'b1;
                        n_pos   = r_idx[AW-1:0];
                        n_carry = i_rdata;
                        n_idx   = idx_inc;
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                // write the carried entry one place up, pick up the one it displaces
                o_we    = 1'b1;
                o_wdata = r_carry;
                n_carry = i_rdata;
                n_idx   = idx_inc;
                if (at_end) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_res_hold) begin
                    o_res_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy               = (r_state != ST_IDLE);
    assign o_res.found          = r_found;
    assign o_res.rejected_full  = r_rej;
    assign o_res.position       = POS_W'(r_pos);
    assign o_res.stored_count   = CNT_W'(r_cnt);

endmodule

`default_nettype wire
